// ===== rtl/btmx_pkg.sv =====
`default_nettype none
package btmx_pkg;

  // Fixed field widths of the stream payload
  localparam int KEY_W = 32;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] STAT_OK    = 2'd0;
  localparam logic [ST_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [KEY_W-1:0] key;
  } cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0] max_xor;
    logic [ST_W-1:0]  status;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/btmx_ram.sv =====
`default_nettype none
module btmx_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/btmx_walker.sv =====
`default_nettype none
module btmx_walker #(
  parameter int KEY_BITS   = 32,
  parameter int NODE_COUNT = 4096
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire btmx_pkg::cmd_t  cmd,
  output logic                 idle,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output btmx_pkg::res_t       res
);

  localparam int NIDX = $clog2(NODE_COUNT);
  localparam int EW   = 2 * NIDX;
  localparam int FW   = $clog2(NODE_COUNT + 1);
  localparam int LW   = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int KW   = btmx_pkg::KEY_W;

  localparam logic [FW-1:0] NODE_LIM = FW'(NODE_COUNT);
  localparam logic [FW-1:0] KEY_LIM  = FW'(KEY_BITS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                  state, state_next;
  logic [LW-1:0]               level, level_next;
  logic [NIDX-1:0]             node, node_next;
  logic                        fresh_cur, fresh_cur_next;
  logic                        dead, dead_next;
  logic [KEY_BITS-1:0]         key_sh, key_sh_next;
  logic [KEY_BITS-1:0]         best, best_next;
  logic [btmx_pkg::OP_W-1:0]   op_q, op_next;
  logic [btmx_pkg::ST_W-1:0]   status_q, status_next;
  logic [EW-1:0]               root_entry, root_next;
  logic [FW-1:0]               next_free, next_free_next;
  logic                        holds_keys, holds_next;

  logic                        wr_en;
  logic [EW-1:0]               wr_data;
  logic [EW-1:0]               rd_data;
  logic [EW-1:0]               entry;
  logic [EW-1:0]               new_entry;
  logic [NIDX-1:0]             c0, c1, tgt_same, tgt_opp, fresh_idx;
  logic                        bit_k;
  logic                        full;

  btmx_ram #(
    .WIDTH (EW),
    .DEPTH (NODE_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (node),
    .wr_data (wr_data),
    .rd_addr (node_next),
    .rd_data (rd_data)
  );

  // Root lives in flops; a freshly allocated node is known empty
  assign entry     = (node == '0) ? root_entry : (fresh_cur ? '0 : rd_data);
  assign c0        = entry[NIDX-1:0];
  assign c1        = entry[EW-1:NIDX];
  assign bit_k     = key_sh[KEY_BITS-1];
  assign tgt_same  = bit_k ? c1 : c0;
  assign tgt_opp   = bit_k ? c0 : c1;
  assign fresh_idx = next_free[NIDX-1:0];
  assign new_entry = bit_k ? {fresh_idx, c0} : {c1, fresh_idx};
  assign full      = (NODE_LIM - next_free) < KEY_LIM;

  always_comb begin
    state_next     = state;
    level_next     = level;
    node_next      = node;
    fresh_cur_next = fresh_cur;
    dead_next      = dead;
    key_sh_next    = key_sh;
    best_next      = best;
    op_next        = op_q;
    status_next    = status_q;
    root_next      = root_entry;
    next_free_next = next_free;
    holds_next     = holds_keys;
    wr_en          = 1'b0;
    wr_data        = new_entry;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          key_sh_next    = cmd.key[KEY_BITS-1:0];
          level_next     = LW'(KEY_BITS - 1);
          node_next      = '0;
          fresh_cur_next = 1'b0;
          dead_next      = 1'b0;
          best_next      = '0;
          op_next        = cmd.operation;
          status_next    = btmx_pkg::STAT_OK;
          state_next     = S_DONE;
          unique case (cmd.operation)
            btmx_pkg::OP_INSERT: begin
              if (full) begin
                status_next = btmx_pkg::STAT_FULL;
              end else begin
                state_next = S_WALK;
              end
            end
            btmx_pkg::OP_QUERY: begin
              if (!holds_keys) begin
                status_next = btmx_pkg::STAT_EMPTY;
              end else begin
                state_next = S_WALK;
              end
            end
            btmx_pkg::OP_CLEAR: begin
              root_next      = '0;
              next_free_next = FW'(1);
              holds_next     = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        key_sh_next = key_sh << 1;
        level_next  = level - LW'(1);
        if (op_q == btmx_pkg::OP_INSERT) begin
          if (tgt_same == '0) begin
            // allocate a node and hook it under the current one
            if (node == '0) begin
              root_next = new_entry;
            end else begin
              wr_en = 1'b1;
            end
            next_free_next = next_free + FW'(1);
            node_next      = fresh_idx;
            fresh_cur_next = 1'b1;
          end else begin
            node_next      = tgt_same;
            fresh_cur_next = 1'b0;
          end
        end else begin
          best_next      = best << 1;
          fresh_cur_next = 1'b0;
          if (dead) begin
            node_next = node;
          end else if (tgt_opp != '0) begin
            best_next = (best << 1) | KEY_BITS'(1);
            node_next = tgt_opp;
          end else if (tgt_same != '0) begin
            node_next = tgt_same;
          end else begin
            dead_next = 1'b1;
          end
        end
        if (level == '0) begin
          state_next = S_DONE;
          if (op_q == btmx_pkg::OP_INSERT) begin
            holds_next = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      level      <= '0;
      node       <= '0;
      fresh_cur  <= 1'b0;
      dead       <= 1'b0;
      op_q       <= btmx_pkg::OP_INSERT;
      status_q   <= btmx_pkg::STAT_OK;
      root_entry <= '0;
      next_free  <= FW'(1);
      holds_keys <= 1'b0;
    end else begin
      state      <= state_next;
      level      <= level_next;
      node       <= node_next;
      fresh_cur  <= fresh_cur_next;
      dead       <= dead_next;
      op_q       <= op_next;
      status_q   <= status_next;
      root_entry <= root_next;
      next_free  <= next_free_next;
      holds_keys <= holds_next;
    end
  end

  always_ff @(posedge clk) begin
    key_sh <= key_sh_next;
    best   <= best_next;
  end

  assign idle        = (state == S_IDLE);
  assign res_valid   = (state == S_DONE);
  assign res.max_xor = KW'(best);
  assign res.status  = status_q;

endmodule
`default_nettype wire

// ===== rtl/binary_trie_max_xor.sv =====
`default_nettype none
// Binary trie maximum-XOR engine. Each input beat carries an operation in
// s_axis_tuser and a key in s_axis_tdata: insert adds the key's path to a
// trie held in a node pool of NODE_COUNT entries, query returns the largest
// key XOR any stored key, clear empties the trie in one step. Every input
// beat yields exactly one output beat with max_xor in m_axis_tdata and a
// status in m_axis_tuser (0 ok, 1 query on an empty trie, 2 insert dropped
// because fewer than KEY_BITS nodes remain). Key bits at and above KEY_BITS
// are ignored. Insert and query walk one trie level per cycle through a
// single-port-write, registered-read node memory; clear, a rejected insert,
// an empty query and the unused operation code skip the walk and go
// straight to the result. The block handles one item at a time:
// s_axis_tready is high only while the walker is idle. A finished result
// sits in the output register, so the next beat can be taken while the
// downstream side still stalls. The node memory needs no clearing after
// reset: the root lives in flops and a freshly allocated node reads as empty.
module binary_trie_max_xor #(
  parameter int KEY_BITS   = 32,
  parameter int NODE_COUNT = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [btmx_pkg::KEY_W-1:0]    s_axis_tdata,   // [31:0] key
  input  wire logic [btmx_pkg::OP_W-1:0]     s_axis_tuser,   // [1:0] operation
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [btmx_pkg::KEY_W-1:0]    m_axis_tdata,   // [31:0] max_xor
  output logic      [btmx_pkg::ST_W-1:0]     m_axis_tuser    // [1:0] status
);

  btmx_pkg::cmd_t cmd;
  btmx_pkg::res_t wk_res;
  btmx_pkg::res_t out_res;
  logic           wk_idle;
  logic           wk_valid;
  logic           wk_ready;
  logic           out_valid;

  assign cmd.operation = s_axis_tuser;
  assign cmd.key       = s_axis_tdata;

  // take a new beat only while the walker is idle
  assign s_axis_tready = wk_idle;

  // the output register takes a result when empty or draining
  assign wk_ready = !out_valid || m_axis_tready;

  btmx_walker #(
    .KEY_BITS   (KEY_BITS),
    .NODE_COUNT (NODE_COUNT)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .start     (s_axis_tvalid && s_axis_tready),
    .cmd       (cmd),
    .idle      (wk_idle),
    .res_valid (wk_valid),
    .res_ready (wk_ready),
    .res       (wk_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wk_ready) begin
      out_valid <= wk_valid;
    end
  end

  // hold the payload while the downstream side stalls
  always_ff @(posedge clk) begin
    if (wk_ready && wk_valid) begin
      out_res <= wk_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_res.max_xor;
  assign m_axis_tuser  = out_res.status;

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int KEY_BITS = 32;
  localparam int NODES    = 4096;

  typedef logic [btmx_pkg::OP_W-1:0]  op_t;
  typedef logic [btmx_pkg::KEY_W-1:0] key_t;
  typedef logic [btmx_pkg::ST_W-1:0]  st_t;

  // Operation code 3 is unused by the block and must act as a no-op
  localparam op_t OP_NOP = 2'd3;

  typedef struct {
    op_t  op;
    key_t key;
    bit   drain_first;  // hold this beat until every result is back
  } trie_cmd_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  key_t             s_tdata = '0;
  op_t              s_tuser = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  key_t             m_tdata;
  st_t              m_tuser;

  trie_cmd_t        cmd_backlog [$];
  btmx_pkg::res_t   expected_results [$];
  key_t             stored_keys [$];
  int               cmd_total = 1 << 30;
  int               sent_count = 0;
  int               fail_count = 0;
  int               send_gap = 0;
  int               stall_left = 0;
  logic             calm;

  // Shadow trie: child index 0 means no child
  int unsigned      kid [NODES][2];
  int unsigned      free_node;
  bit               trie_nonempty;

  always #5 clk = ~clk;

  binary_trie_max_xor #(
    .KEY_BITS   (KEY_BITS),
    .NODE_COUNT (NODES)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),   // [31:0] key
    .s_axis_tuser  (s_tuser),   // [1:0] operation
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),   // [31:0] max_xor
    .m_axis_tuser  (m_tuser)    // [1:0] status
  );

  // No idling in the last 200 beats, and a quiet stretch every fourth block of 128
  assign calm = (sent_count + 200 >= cmd_total) || ((sent_count / 128) % 4 == 3);

  // Apply one operation to the shadow trie and return the answer it should give
  function automatic btmx_pkg::res_t trie_apply(op_t op, key_t key);
    btmx_pkg::res_t r;
    int unsigned    node;
    int unsigned    fresh;
    int             i;
    bit             b;
    r.max_xor = '0;
    r.status  = btmx_pkg::STAT_OK;
    node      = 0;
    case (op)
      btmx_pkg::OP_INSERT: begin
        // Reject when fewer than KEY_BITS nodes remain, even for a stored key
        if (NODES - free_node < KEY_BITS) begin
          r.status = btmx_pkg::STAT_FULL;
        end else begin
          for (i = KEY_BITS - 1; i >= 0; i--) begin
            b = key[i];
            if (kid[node][b] == 0) begin
              fresh = free_node;
              kid[fresh][0] = 0;
              kid[fresh][1] = 0;
              kid[node][b] = fresh;
              free_node = fresh + 1;
            end
            node = kid[node][b];
          end
          trie_nonempty = 1'b1;
        end
      end
      btmx_pkg::OP_QUERY: begin
        if (!trie_nonempty) begin
          r.status = btmx_pkg::STAT_EMPTY;
        end else begin
          // Prefer the opposite bit at every level
          for (i = KEY_BITS - 1; i >= 0; i--) begin
            b = key[i];
            if (kid[node][!b] != 0) begin
              r.max_xor[i] = 1'b1;
              node = kid[node][!b];
            end else if (kid[node][b] != 0) begin
              node = kid[node][b];
            end else begin
              break;
            end
          end
        end
      end
      btmx_pkg::OP_CLEAR: begin
        kid[0][0] = 0;
        kid[0][1] = 0;
        free_node = 1;
        trie_nonempty = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_cmd(op_t op, key_t key, bit drain = 1'b0);
    trie_cmd_t c;
    c.op = op;
    c.key = key;
    c.drain_first = drain;
    cmd_backlog.insert(cmd_backlog.size(), c);
    if (op == btmx_pkg::OP_INSERT) begin
      stored_keys.insert(stored_keys.size(), key);
      if (stored_keys.size() > 256) void'(stored_keys.pop_front());
    end else if (op == btmx_pkg::OP_CLEAR) begin
      stored_keys.delete();
    end
  endtask

  // Mix of wide random keys, tiny keys, near-all-ones keys and near misses of stored keys
  function automatic key_t pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 3) return $urandom;
    if (sel == 4) return $urandom_range(0, 15);
    if (sel == 5) return 32'hFFFF_FFF0 | $urandom_range(0, 15);
    if (stored_keys.size() == 0) return $urandom;
    return stored_keys[$urandom_range(0, stored_keys.size() - 1)] ^
           (32'h1 << $urandom_range(0, 31));
  endfunction

  // Fill the pool until inserts bounce, then probe it and empty it
  task automatic plan_fill();
    int j;
    add_cmd(btmx_pkg::OP_CLEAR, $urandom);
    for (j = 0; j < 200; j++) add_cmd(btmx_pkg::OP_INSERT, $urandom);
    for (j = 0; j < 4; j++) begin
      add_cmd(btmx_pkg::OP_INSERT, stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
      add_cmd(btmx_pkg::OP_QUERY, pick_key());
    end
    add_cmd(btmx_pkg::OP_CLEAR, $urandom);
    add_cmd(btmx_pkg::OP_INSERT, pick_key());
  endtask

  task automatic plan_session();
    int n_ins;
    int n_q;
    int j;
    if ($urandom_range(0, 3) == 0) add_cmd(btmx_pkg::OP_CLEAR, $urandom);
    n_ins = $urandom_range(1, 24);
    n_q   = $urandom_range(1, 16);
    for (j = 0; j < n_ins; j++) add_cmd(btmx_pkg::OP_INSERT, pick_key());
    for (j = 0; j < n_q; j++) begin
      if ($urandom_range(0, 5) == 0) add_cmd(btmx_pkg::OP_INSERT, pick_key());
      else add_cmd(btmx_pkg::OP_QUERY, pick_key());
    end
  endtask

  task automatic plan_noise();
    int n;
    int j;
    n = $urandom_range(1, 10);
    for (j = 0; j < n; j++) add_cmd(op_t'($urandom_range(0, 3)), $urandom);
  endtask

  // Driver: present the head of the backlog, predict on every accepted beat
  always @(posedge clk) begin
    logic nxt_valid;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      nxt_valid = s_tvalid;
      if (s_tvalid && s_tready) begin
        expected_results.insert(expected_results.size(),
                                trie_apply(cmd_backlog[0].op, cmd_backlog[0].key));
        void'(cmd_backlog.pop_front());
        sent_count++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 12) - 1;
        end else if (cmd_backlog.size() > 0 &&
                     !(cmd_backlog[0].drain_first && expected_results.size() != 0)) begin
          nxt_valid = 1'b1;
          s_tdata <= cmd_backlog[0].key;
          s_tuser <= cmd_backlog[0].op;
        end
      end
      s_tvalid <= nxt_valid;
    end
  end

  // Receiver: stall in random bursts outside the calm stretches
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Monitor: check every accepted result beat against the oldest expectation
  always @(posedge clk) begin
    btmx_pkg::res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected beat: expected none, actual max_xor %h status %0d",
                 $time, m_tdata, m_tuser);
      end else begin
        want = expected_results.pop_front();
        if (m_tdata !== want.max_xor) begin
          fail_count++;
          $display("%0t: max_xor mismatch: expected %h, actual %h",
                   $time, want.max_xor, m_tdata);
        end
        if (m_tuser !== want.status) begin
          fail_count++;
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, m_tuser);
        end
      end
    end
  end

  initial begin
    int sel;
    int seq_no;
    kid[0][0] = 0;
    kid[0][1] = 0;
    free_node = 1;
    trie_nonempty = 1'b0;

    // Directed: empty trie, unused code, extremes, duplicates, clear
    add_cmd(btmx_pkg::OP_QUERY,  32'h0000_0000);
    add_cmd(OP_NOP,              32'hFFFF_FFFF);
    add_cmd(btmx_pkg::OP_CLEAR,  32'hFFFF_FFFF);
    add_cmd(btmx_pkg::OP_QUERY,  32'hFFFF_FFFF);
    add_cmd(btmx_pkg::OP_INSERT, 32'h0000_0000);
    add_cmd(btmx_pkg::OP_QUERY,  32'h0000_0000);
    add_cmd(btmx_pkg::OP_INSERT, 32'hFFFF_FFFF);
    add_cmd(btmx_pkg::OP_QUERY,  32'h0000_0000);
    add_cmd(btmx_pkg::OP_QUERY,  32'hFFFF_FFFF);
    add_cmd(btmx_pkg::OP_QUERY,  32'h8000_0000);
    add_cmd(btmx_pkg::OP_INSERT, 32'hFFFF_FFFF);
    add_cmd(btmx_pkg::OP_INSERT, 32'hA5A5_A5A5);
    add_cmd(btmx_pkg::OP_QUERY,  32'h5A5A_5A5A);
    add_cmd(OP_NOP,              32'h1234_5678);
    add_cmd(btmx_pkg::OP_CLEAR,  32'h0000_0000);
    add_cmd(btmx_pkg::OP_QUERY,  32'h0000_0001);
    add_cmd(btmx_pkg::OP_INSERT, 32'h0000_0001);
    add_cmd(btmx_pkg::OP_QUERY,  32'hFFFF_FFFE);
    add_cmd(btmx_pkg::OP_QUERY,  32'h0000_0001);
    add_cmd(btmx_pkg::OP_CLEAR,  32'h0000_0000);

    // Random: mostly insert/query sessions, pool fills, noise, drain points
    seq_no = 0;
    while (cmd_backlog.size() < 1520) begin
      sel = $urandom_range(0, 19);
      if (seq_no == 0 || sel == 0) begin
        plan_fill();
      end else if (seq_no == 1 || sel == 1) begin
        // wait for the pipeline to empty, then resume with a session
        add_cmd(btmx_pkg::OP_QUERY, pick_key(), 1'b1);
        plan_session();
      end else if (sel <= 3) begin
        plan_noise();
      end else begin
        plan_session();
      end
      seq_no++;
    end
    cmd_total = cmd_backlog.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (sent_count < cmd_total) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
